// ----- rtl/json_string_unescape_utf8_defines.svh -----
// ============================================================================
// JSON string unescaper - assertion macros
// Shared concurrent assertion forms, reset-qualified on the sync active-low
// reset.
// ============================================================================
`ifndef JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH

// Same-cycle implication
`define JSU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define JSU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/jsu_pkg.sv -----
// ============================================================================
// JSON string unescaper - package
// Request/result types, status codes, burst record and decode helpers.
// ============================================================================
`timescale 1ns / 1ps

package jsu_pkg;

    // Result status codes
    localparam logic [2:0] ST_DATA   = 3'd0;
    localparam logic [2:0] ST_END    = 3'd1;
    localparam logic [2:0] ST_EARLY  = 3'd2;
    localparam logic [2:0] ST_BADHEX = 3'd3;
    localparam logic [2:0] ST_NOLOW  = 3'd4;
    localparam logic [2:0] ST_STRAY  = 3'd5;
    localparam logic [2:0] ST_BADESC = 3'd6;
    localparam logic [2:0] ST_CTRL   = 3'd7;

    // Burst queue sizing
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [7:0] in_byte;
        logic       at_end;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] status;
        logic       last;
    } t_out;

    // Results caused by one request: up to four bytes, sent from index 0
    typedef struct packed {
        logic [3:0][7:0] data;
        logic [1:0]      cnt_m1;
        logic [2:0]      status;
    } t_burst;

    // Queue status seen by both sides
    typedef struct packed {
        logic empty;
        logic full;
    } t_qstat;

    // Hex digit decode: bit 4 set means not a hex digit
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) v = {1'b0, c[3:0]};
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
            v = {1'b0, c[3:0] + 4'd9};
        return v;
    endfunction

endpackage

// ----- rtl/jsu_front.sv -----
// ============================================================================
// JSON string unescaper - front end
// Runs the escape state machine on each accepted byte and, when it gives a
// result, pushes a burst record (one to four results) into the burst queue.
// ============================================================================
`timescale 1ns / 1ps

module jsu_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  jsu_pkg::t_in   i_req,
    output logic           o_push,
    output jsu_pkg::t_burst o_burst
);
    import jsu_pkg::*;

    typedef enum logic [5:0] {
        S_PLAIN   = 6'b000001,
        S_ESC     = 6'b000010,
        S_HEX1    = 6'b000100,
        S_WANT_BS = 6'b001000,
        S_WANT_U  = 6'b010000,
        S_HEX2    = 6'b100000
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [1:0]  r_digit, n_digit;
    logic [15:0] r_first, n_first;
    logic [15:0] r_second, n_second;

    logic [4:0]  w_hex;
    logic [15:0] w_unit1, w_unit2;
    logic [10:0] w_plane;
    logic [20:0] w_cp;
    logic [7:0]  c;

    assign c       = i_req.in_byte;
    assign w_hex   = hex_val(c);
    assign w_unit1 = {r_first[11:0], w_hex[3:0]};
    assign w_unit2 = {r_second[11:0], w_hex[3:0]};
    // 0x10000 + (hi[9:0] << 10 | lo[9:0])
    assign w_plane = {1'b0, r_first[9:0]} + 11'h040;
    assign w_cp    = {w_plane, w_unit2[9:0]};

    // Next state and burst build
    always_comb begin
        n_phase  = r_phase;
        n_digit  = r_digit;
        n_first  = r_first;
        n_second = r_second;
        o_push   = 1'b0;
        o_burst  = '0;
        if (i_accept) begin
            if (i_req.at_end) begin
                o_push         = 1'b1;
                o_burst.status = ST_EARLY;
                n_phase        = S_PLAIN;
            end else begin
                case (r_phase)
                    S_PLAIN: begin
                        if (c == 8'h22) begin
                            o_push         = 1'b1;
                            o_burst.status = ST_END;
                        end else if (c == 8'h5c) begin
                            n_phase = S_ESC;
                        end else if (c < 8'h20 || c == 8'h7f) begin
                            o_push         = 1'b1;
                            o_burst.status = ST_CTRL;
                        end else begin
                            o_push          = 1'b1;
                            o_burst.data[0] = c;
                        end
                    end
                    S_ESC: begin
                        n_phase = S_PLAIN;
                        o_push  = 1'b1;
                        case (c)
                            8'h75: begin
                                o_push  = 1'b0;
                                n_phase = S_HEX1;
                                n_digit = 2'd0;
                            end
                            8'h22, 8'h5c, 8'h2f: o_burst.data[0] = c;
                            8'h62: o_burst.data[0] = 8'h08;
                            8'h66: o_burst.data[0] = 8'h0c;
                            8'h6e: o_burst.data[0] = 8'h0a;
                            8'h72: o_burst.data[0] = 8'h0d;
                            8'h74: o_burst.data[0] = 8'h09;
                            default: o_burst.status = ST_BADESC;
                        endcase
                    end
                    S_HEX1: begin
                        if (w_hex[4]) begin
                            o_push         = 1'b1;
                            o_burst.status = ST_BADHEX;
                            n_phase        = S_PLAIN;
                        end else begin
                            n_first = w_unit1;
                            n_digit = r_digit + 2'd1;
                            if (r_digit == 2'd3) begin
                                n_phase = S_PLAIN;
                                o_push  = 1'b1;
                                if (w_unit1[15:7] == '0) begin
                                    o_burst.data[0] = w_unit1[7:0];
                                end else if (w_unit1[15:11] == '0) begin
                                    o_burst.data[0] = {3'b110, w_unit1[10:6]};
                                    o_burst.data[1] = {2'b10, w_unit1[5:0]};
                                    o_burst.cnt_m1  = 2'd1;
                                end else if (w_unit1[15:10] == 6'b110110) begin
                                    o_push  = 1'b0;
                                    n_phase = S_WANT_BS;
                                end else if (w_unit1[15:10] == 6'b110111) begin
                                    o_burst.status = ST_STRAY;
                                end else begin
                                    o_burst.data[0] = {4'b1110, w_unit1[15:12]};
                                    o_burst.data[1] = {2'b10, w_unit1[11:6]};
                                    o_burst.data[2] = {2'b10, w_unit1[5:0]};
                                    o_burst.cnt_m1  = 2'd2;
                                end
                            end
                        end
                    end
                    S_WANT_BS: begin
                        if (c == 8'h5c) begin
                            n_phase = S_WANT_U;
                        end else begin
                            o_push         = 1'b1;
                            o_burst.status = ST_NOLOW;
                            n_phase        = S_PLAIN;
                        end
                    end
                    S_WANT_U: begin
                        if (c == 8'h75) begin
                            n_phase = S_HEX2;
                            n_digit = 2'd0;
                        end else begin
                            o_push         = 1'b1;
                            o_burst.status = ST_NOLOW;
                            n_phase        = S_PLAIN;
                        end
                    end
                    S_HEX2: begin
                        if (w_hex[4]) begin
                            o_push         = 1'b1;
                            o_burst.status = ST_BADHEX;
                            n_phase        = S_PLAIN;
                        end else begin
                            n_second = w_unit2;
                            n_digit  = r_digit + 2'd1;
                            if (r_digit == 2'd3) begin
                                n_phase = S_PLAIN;
                                o_push  = 1'b1;
                                if (w_unit2[15:10] != 6'b110111) begin
                                    o_burst.status = ST_NOLOW;
                                end else begin
                                    o_burst.data[0] = {5'b11110, w_cp[20:18]};
                                    o_burst.data[1] = {2'b10, w_cp[17:12]};
                                    o_burst.data[2] = {2'b10, w_cp[11:6]};
                                    o_burst.data[3] = {2'b10, w_cp[5:0]};
                                    o_burst.cnt_m1  = 2'd3;
                                end
                            end
                        end
                    end
                    default: n_phase = S_PLAIN;
                endcase
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= S_PLAIN;
            r_digit <= 2'd0;
        end else begin
            r_phase <= n_phase;
            r_digit <= n_digit;
        end
    end

    // Code unit accumulators
    always_ff @(posedge i_clk) begin
        r_first  <= n_first;
        r_second <= n_second;
    end

endmodule

// ----- rtl/jsu_queue.sv -----
// ============================================================================
// JSON string unescaper - burst queue
// Small register FIFO of burst records between the front and back ends.
// ============================================================================
`timescale 1ns / 1ps

module jsu_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  jsu_pkg::t_burst i_burst,
    input  logic            i_pop,
    output jsu_pkg::t_burst o_head,
    output jsu_pkg::t_qstat o_stat
);
    import jsu_pkg::*;

    t_burst           r_mem [QDEPTH];
    logic [QAW-1:0]   r_wr, r_rd;
    logic [QCW-1:0]   r_cnt, n_cnt;
    logic             w_push, w_pop;

    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.full  = (r_cnt == QCW'(QDEPTH));
    assign w_push       = i_push && !o_stat.full;
    assign w_pop        = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rd];

    // Occupancy
    always_comb begin
        n_cnt = r_cnt;
        if (w_push && !w_pop) n_cnt = r_cnt + QCW'(1);
        else if (w_pop && !w_push) n_cnt = r_cnt - QCW'(1);
    end

    // Pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wr <= r_wr + QAW'(1);
            if (w_pop)  r_rd <= r_rd + QAW'(1);
            r_cnt <= n_cnt;
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr] <= i_burst;
    end

endmodule

// ----- rtl/jsu_back.sv -----
// ============================================================================
// JSON string unescaper - back end
// Walks the head burst one result per cycle, while the output is taken, into
// the output register and marks the final result of each burst.
// ============================================================================
`timescale 1ns / 1ps

module jsu_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  jsu_pkg::t_burst i_head,
    input  jsu_pkg::t_qstat i_qstat,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output jsu_pkg::t_out   o_res
);
    import jsu_pkg::*;

    logic [1:0] r_idx;
    logic       r_valid;
    t_out       r_res, n_res;
    logic       w_load, w_last;

    assign w_load = (!r_valid || i_ready) && !i_qstat.empty;
    assign w_last = (r_idx == i_head.cnt_m1);
    assign o_pop  = w_load && w_last;

    // Next result from the head burst
    always_comb begin
        n_res.out_byte = i_head.data[r_idx];
        n_res.status   = i_head.status;
        n_res.last     = w_last;
    end

    // Control: output valid and position within burst
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_idx   <= w_last ? 2'd0 : r_idx + 2'd1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (w_load) r_res <= n_res;
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ----- rtl/json_string_unescape_utf8.sv -----
// ============================================================================
// JSON string unescaper to UTF-8 - top level
// Takes one string-body byte per request (or an end-of-input marker) and
// returns the decoded UTF-8 bytes, then a status result on the closing quote
// or on an error; the final result of each request carries last. A request
// is taken every cycle while the four-entry burst queue has room; the output
// side emits one result per cycle while the result port takes it. A plain
// byte or simple escape gives one result, a \u escape one to three and a
// surrogate pair four, and the queue drain rate on the result port is what
// sets sustained rate during such bursts. Bytes inside an escape produce no
// result. Each result is held in the burst queue and then the output register.
// ============================================================================
`timescale 1ns / 1ps
`include "json_string_unescape_utf8_defines.svh"

module json_string_unescape_utf8 (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  jsu_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output jsu_pkg::t_out o_out_data
);
    import jsu_pkg::*;

    logic   w_accept, w_push, w_pop;
    t_burst w_burst, w_head;
    t_qstat w_qstat;

    assign o_in_ready = !w_qstat.full;
    assign w_accept   = i_in_valid && o_in_ready;

    // Front end: escape decoding
    jsu_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_req    (i_in_data),
        .o_push   (w_push),
        .o_burst  (w_burst)
    );

    // Burst queue
    jsu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_burst (w_burst),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_qstat)
    );

    // Back end: result serializer
    jsu_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .i_qstat (w_qstat),
        .o_pop   (w_pop),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_res   (o_out_data)
    );

    // Checks
    `JSU_ASSERT_NOW(a_err_is_last, i_clk, i_rst_n, o_out_valid && (o_out_data.status != ST_DATA), o_out_data.last, "status result not marked last")
    `JSU_ASSERT_NEXT(a_burst_continues, i_clk, i_rst_n, o_out_valid && !o_out_data.last, o_out_valid, "burst interrupted before last result")
    `JSU_ASSERT_NEXT(a_end_queued, i_clk, i_rst_n, w_accept && i_in_data.at_end, !w_qstat.empty, "end of input produced no queued result")
    `JSU_ASSERT_NOW(a_queue_sane, i_clk, i_rst_n, 1'b1, !(w_qstat.empty && w_qstat.full), "queue both empty and full")

endmodule

// ----- tb/sv/json_string_unescape_utf8_tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// JSON string unescaper to UTF-8 - testbench
// Feeds string-body bytes and end-of-input markers through the request port
// and compares every result with a local decoder model or a typed-in result.
// A short directed table comes first, then mostly well-formed random strings
// with escapes, \u units and surrogate pairs mixed with broken sequences.
// Both ports idle at random, and the result side holds off once long enough
// to back up the request side.
// ============================================================================

module json_string_unescape_utf8_tb;
    import jsu_pkg::*;

    // Decoder phases
    localparam logic [3:0] PH_PLAIN   = 4'd0;
    localparam logic [3:0] PH_ESC     = 4'd1;
    localparam logic [3:0] PH_HEX1    = 4'd2;   // 2..5
    localparam logic [3:0] PH_WANT_BS = 4'd6;
    localparam logic [3:0] PH_WANT_U  = 4'd7;
    localparam logic [3:0] PH_HEX2    = 4'd8;   // 8..11

    // Characters with a role in the syntax
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_U      = 8'h75;

    localparam int N_RANDOM     = 182;
    localparam int MAX_WAIT     = 12;
    localparam int HOLD_AT      = 40;   // result count at which the long hold-off starts
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       at_end;
        logic       fixed;      // expected result typed in below
        logic [7:0] x_byte;
        logic [2:0] x_status;
    } dir_row_t;

    typedef struct packed {
        t_in  req;
        logic fixed;
        t_out x_res;
    } stim_t;

    // Directed requests; fixed rows expect exactly one result
    dir_row_t dir_tbl [0:27] = '{
        '{8'h00, 1'b1, 1'b1, 8'h00, ST_EARLY},   // end of input right after reset
        '{8'h1f, 1'b0, 1'b1, 8'h00, ST_CTRL},
        '{8'h7f, 1'b0, 1'b1, 8'h00, ST_CTRL},
        '{8'h00, 1'b0, 1'b1, 8'h00, ST_CTRL},
        '{8'hff, 1'b0, 1'b1, 8'hff, ST_DATA},    // high bytes pass through
        '{8'h20, 1'b0, 1'b1, 8'h20, ST_DATA},
        '{8'h80, 1'b0, 1'b1, 8'h80, ST_DATA},
        '{8'h22, 1'b0, 1'b1, 8'h00, ST_END},     // closing quote
        '{8'h5c, 1'b0, 1'b0, 8'h00, ST_DATA},    // unknown escape letter
        '{8'h7a, 1'b0, 1'b1, 8'h00, ST_BADESC},
        '{8'h5c, 1'b0, 1'b0, 8'h00, ST_DATA},    // \ug
        '{8'h75, 1'b0, 1'b0, 8'h00, ST_DATA},
        '{8'h67, 1'b0, 1'b1, 8'h00, ST_BADHEX},
        '{8'h5c, 1'b0, 1'b0, 8'h00, ST_DATA},    // \uDc00: lone low surrogate
        '{8'h75, 1'b0, 1'b0, 8'h00, ST_DATA},
        '{8'h44, 1'b0, 1'b0, 8'h00, ST_DATA},
        '{8'h63, 1'b0, 1'b0, 8'h00, ST_DATA},
        '{8'h30, 1'b0, 1'b0, 8'h00, ST_DATA},
        '{8'h30, 1'b0, 1'b1, 8'h00, ST_STRAY},
        '{8'h5c, 1'b0, 1'b0, 8'h00, ST_DATA},    // \ud800 then 'A': no low half
        '{8'h75, 1'b0, 1'b0, 8'h00, ST_DATA},
        '{8'h64, 1'b0, 1'b0, 8'h00, ST_DATA},
        '{8'h38, 1'b0, 1'b0, 8'h00, ST_DATA},
        '{8'h30, 1'b0, 1'b0, 8'h00, ST_DATA},
        '{8'h30, 1'b0, 1'b0, 8'h00, ST_DATA},
        '{8'h41, 1'b0, 1'b1, 8'h00, ST_NOLOW},
        '{8'h5c, 1'b0, 1'b0, 8'h00, ST_DATA},    // input ends inside an escape
        '{8'hff, 1'b1, 1'b1, 8'h00, ST_EARLY}
    };

    logic  i_clk       = 1'b0;
    logic  i_rst_n     = 1'b0;
    logic  i_in_valid  = 1'b0;
    t_in   i_in_data   = '0;
    logic  i_out_ready = 1'b0;
    logic  o_in_ready;
    logic  o_out_valid;
    t_out  o_out_data;

    // Decoder model state
    logic [3:0]  dec_phase  = PH_PLAIN;
    logic [15:0] lead_unit  = '0;
    logic [15:0] trail_unit = '0;

    t_out  step_q[$];       // results of the request being decoded
    t_out  utf8_exp_q[$];   // results still owed by the block
    stim_t stim_q[$];
    int    errors = 0;

    json_string_unescape_utf8 dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------------
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = c - 8'h57;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = c - 8'h37;
        end else begin
            return 5'h10;
        end
        return {1'b0, d[3:0]};
    endfunction

    // {known, byte} for the single-letter escapes
    function automatic logic [8:0] simple_escape(input logic [7:0] c);
        case (c)
            8'h22:   return {1'b1, 8'h22};
            8'h5c:   return {1'b1, 8'h5c};
            8'h2f:   return {1'b1, 8'h2f};
            8'h62:   return {1'b1, 8'h08};   // b
            8'h66:   return {1'b1, 8'h0c};   // f
            8'h6e:   return {1'b1, 8'h0a};   // n
            8'h72:   return {1'b1, 8'h0d};   // r
            8'h74:   return {1'b1, 8'h09};   // t
            default: return 9'h000;
        endcase
    endfunction

    function automatic void emit_byte(input logic [7:0] b);
        step_q.push_back('{b, ST_DATA, 1'b0});
    endfunction

    // Status result: the string is over, decoder starts fresh
    function automatic void end_string(input logic [2:0] st);
        step_q.push_back('{8'h00, st, 1'b0});
        dec_phase  = PH_PLAIN;
        lead_unit  = '0;
        trail_unit = '0;
    endfunction

    task automatic decode_request(input t_in r);
        logic [7:0]  c;
        logic [4:0]  h;
        logic [8:0]  esc;
        logic [20:0] cp;
        c = r.in_byte;
        step_q.delete();
        if (r.at_end) begin
            end_string(ST_EARLY);
        end else if (dec_phase == PH_PLAIN) begin
            if (c == CH_QUOTE) end_string(ST_END);
            else if (c == CH_BSLASH) dec_phase = PH_ESC;
            else if (c < 8'h20 || c == 8'h7f) end_string(ST_CTRL);
            else emit_byte(c);
        end else if (dec_phase == PH_ESC) begin
            esc = simple_escape(c);
            if (c == CH_U) begin
                lead_unit = '0;
                dec_phase = PH_HEX1;
            end else if (esc[8]) begin
                dec_phase = PH_PLAIN;
                emit_byte(esc[7:0]);
            end else begin
                end_string(ST_BADESC);
            end
        end else if (dec_phase >= PH_HEX1 && dec_phase <= PH_HEX1 + 4'd3) begin
            h = hex_nibble(c);
            if (h[4]) begin
                end_string(ST_BADHEX);
            end else begin
                lead_unit = {lead_unit[11:0], h[3:0]};
                if (dec_phase != PH_HEX1 + 4'd3) begin
                    dec_phase = dec_phase + 4'd1;
                end else if (lead_unit < 16'h0080) begin
                    dec_phase = PH_PLAIN;
                    emit_byte(lead_unit[7:0]);
                end else if (lead_unit < 16'h0800) begin
                    dec_phase = PH_PLAIN;
                    emit_byte({3'b110, lead_unit[10:6]});
                    emit_byte({2'b10, lead_unit[5:0]});
                end else if (lead_unit >= 16'hd800 && lead_unit <= 16'hdbff) begin
                    dec_phase = PH_WANT_BS;
                end else if (lead_unit >= 16'hdc00 && lead_unit <= 16'hdfff) begin
                    end_string(ST_STRAY);
                end else begin
                    dec_phase = PH_PLAIN;
                    emit_byte({4'b1110, lead_unit[15:12]});
                    emit_byte({2'b10, lead_unit[11:6]});
                    emit_byte({2'b10, lead_unit[5:0]});
                end
            end
        end else if (dec_phase == PH_WANT_BS) begin
            if (c == CH_BSLASH) dec_phase = PH_WANT_U;
            else end_string(ST_NOLOW);
        end else if (dec_phase == PH_WANT_U) begin
            if (c == CH_U) begin
                trail_unit = '0;
                dec_phase  = PH_HEX2;
            end else begin
                end_string(ST_NOLOW);
            end
        end else begin
            // low half digits
            h = hex_nibble(c);
            if (h[4]) begin
                end_string(ST_BADHEX);
            end else begin
                trail_unit = {trail_unit[11:0], h[3:0]};
                if (dec_phase != PH_HEX2 + 4'd3) begin
                    dec_phase = dec_phase + 4'd1;
                end else if (trail_unit < 16'hdc00 || trail_unit > 16'hdfff) begin
                    end_string(ST_NOLOW);
                end else begin
                    cp = 21'h10000 + {1'b0, lead_unit[9:0], trail_unit[9:0]};
                    dec_phase  = PH_PLAIN;
                    lead_unit  = '0;
                    trail_unit = '0;
                    emit_byte({5'b11110, cp[20:18]});
                    emit_byte({2'b10, cp[17:12]});
                    emit_byte({2'b10, cp[11:6]});
                    emit_byte({2'b10, cp[5:0]});
                end
            end
        end
    endtask

    // Book the results owed for one accepted request
    task automatic log_request(input stim_t s);
        t_out r;
        decode_request(s.req);
        if (s.fixed) begin
            utf8_exp_q.push_back(s.x_res);
        end else begin
            foreach (step_q[i]) begin
                r      = step_q[i];
                r.last = (i == step_q.size() - 1);
                utf8_exp_q.push_back(r);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------------
    task automatic add_item(input logic [7:0] b, input logic e);
        stim_t s;
        s.req.in_byte = b;
        s.req.at_end  = e;
        s.fixed       = 1'b0;
        s.x_res       = '0;
        stim_q.push_back(s);
    endtask

    // Bias toward the ends of the range
    function automatic logic [15:0] pick16(input logic [15:0] lo, input logic [15:0] hi);
        case ($urandom_range(0, 5))
            0:       return lo;
            1:       return hi;
            default: return 16'($urandom_range(lo, hi));
        endcase
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input logic upper);
        if (n < 4'd10) return 8'h30 + {4'h0, n};
        return (upper ? 8'h37 : 8'h57) + {4'h0, n};
    endfunction

    function automatic logic [7:0] non_hex();
        logic [7:0] c;
        logic [4:0] h;
        do begin
            c = 8'($urandom_range(0, 255));
            h = hex_nibble(c);
        end while (!h[4]);
        return c;
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] c;
        if ($urandom_range(0, 3) == 0) return 8'($urandom_range(128, 255));
        c = 8'($urandom_range(32, 126));
        if (c == CH_QUOTE || c == CH_BSLASH) c = 8'h61;
        return c;
    endfunction

    function automatic logic [7:0] esc_letter();
        case ($urandom_range(0, 7))
            0:       return 8'h22;
            1:       return 8'h5c;
            2:       return 8'h2f;
            3:       return 8'h62;
            4:       return 8'h66;
            5:       return 8'h6e;
            6:       return 8'h72;
            default: return 8'h74;
        endcase
    endfunction

    function automatic logic [15:0] bmp_unit();
        logic [15:0] u;
        case ($urandom_range(0, 2))
            0:       u = pick16(16'h0000, 16'h007f);
            1:       u = pick16(16'h0080, 16'h07ff);
            default: u = pick16(16'h0800, 16'hffff);
        endcase
        if (u >= 16'hd800 && u <= 16'hdfff) u = u ^ 16'h4000;
        return u;
    endfunction

    task automatic add_unit(input logic [15:0] u);
        add_item(CH_BSLASH, 1'b0);
        add_item(CH_U, 1'b0);
        for (int k = 3; k >= 0; k--)
            add_item(hex_char(u[4*k +: 4], 1'($urandom_range(0, 1))), 1'b0);
    endtask

    task automatic add_hex_digits(input int n);
        repeat (n)
            add_item(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))), 1'b0);
    endtask

    // Broken sequences and raw noise
    task automatic add_noise();
        logic [15:0] u;
        logic [7:0]  c;
        case ($urandom_range(0, 8))
            0: add_item(8'($urandom_range(0, 255)), 1'b0);
            1: add_item(8'($urandom_range(0, 255)), 1'b1);
            2: add_unit(pick16(16'hdc00, 16'hdfff));
            3: begin
                add_unit(pick16(16'hd800, 16'hdbff));
                add_item(8'($urandom_range(0, 255)), 1'b0);
            end
            4: begin
                add_unit(pick16(16'hd800, 16'hdbff));
                u = 16'($urandom_range(0, 16'hffff));
                if (u >= 16'hdc00 && u <= 16'hdfff) u = u ^ 16'h2000;
                add_unit(u);
            end
            5: begin
                // bad digit in the first or the second unit
                if ($urandom_range(0, 1)) add_unit(pick16(16'hd800, 16'hdbff));
                add_item(CH_BSLASH, 1'b0);
                add_item(CH_U, 1'b0);
                add_hex_digits($urandom_range(0, 3));
                add_item(non_hex(), 1'b0);
            end
            6: begin
                // input ends partway through an escape
                if ($urandom_range(0, 1)) add_unit(pick16(16'hd800, 16'hdbff));
                add_item(CH_BSLASH, 1'b0);
                if ($urandom_range(0, 1)) begin
                    add_item(CH_U, 1'b0);
                    add_hex_digits($urandom_range(0, 3));
                end
                add_item(8'($urandom_range(0, 255)), 1'b1);
            end
            7: begin
                add_unit(pick16(16'hd800, 16'hdbff));
                add_item(CH_BSLASH, 1'b0);
                c = 8'($urandom_range(0, 255));
                if (c == CH_U) c = 8'h78;
                add_item(c, 1'b0);
            end
            default: begin
                add_item(CH_BSLASH, 1'b0);
                add_item(8'($urandom_range(0, 255)), 1'b0);
            end
        endcase
    endtask

    task automatic build_random();
        int sel;
        int base;
        base = stim_q.size();
        while (stim_q.size() < base + N_RANDOM) begin
            sel = $urandom_range(0, 99);
            if (sel < 30) begin
                add_item(plain_byte(), 1'b0);
            end else if (sel < 45) begin
                add_item(CH_BSLASH, 1'b0);
                add_item(esc_letter(), 1'b0);
            end else if (sel < 62) begin
                add_unit(bmp_unit());
            end else if (sel < 74) begin
                add_unit(pick16(16'hd800, 16'hdbff));
                add_unit(pick16(16'hdc00, 16'hdfff));
            end else if (sel < 80) begin
                add_item(CH_QUOTE, 1'b0);
            end else begin
                add_noise();
            end
        end
    endtask

    // Wait before the next request or result; runs of zero waits now and then
    task automatic draw_gap(inout int calm, output int gap);
        if (calm > 0) begin
            calm--;
            gap = 0;
        end else if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(8, 30);
            gap  = 0;
        end else begin
            gap = $urandom_range(0, MAX_WAIT);
        end
    endtask

    // ------------------------------------------------------------------------
    // Request side and end of run
    // ------------------------------------------------------------------------
    initial begin : request_drive
        stim_t s;
        int    gap;
        int    calm;
        foreach (dir_tbl[i]) begin
            s.req.in_byte = dir_tbl[i].in_byte;
            s.req.at_end  = dir_tbl[i].at_end;
            s.fixed       = dir_tbl[i].fixed;
            s.x_res       = '{dir_tbl[i].x_byte, dir_tbl[i].x_status, 1'b1};
            stim_q.push_back(s);
        end
        build_random();
        calm = 0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        draw_gap(calm, gap);
        foreach (stim_q[k]) begin
            s = stim_q[k];
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_in_valid <= 1'b1;
            i_in_data  <= s.req;
            do @(posedge i_clk); while (!o_in_ready);
            log_request(s);
            draw_gap(calm, gap);
        end
        i_in_valid <= 1'b0;

        while (utf8_exp_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: random back-pressure, one long hold-off
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int gap;
        int calm;
        int taken;
        calm  = 0;
        taken = 0;
        wait (i_rst_n);
        forever begin
            draw_gap(calm, gap);
            if (taken == HOLD_AT) gap = HOLD_CYCLES;
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            taken++;
        end
    end

    // Compare each result with the oldest one owed
    always @(posedge i_clk) begin : result_check
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (utf8_exp_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: expected none, got byte %h status %0d last %0b",
                         $time, o_out_data.out_byte, o_out_data.status, o_out_data.last);
            end else begin
                want = utf8_exp_q.pop_front();
                if (o_out_data.out_byte !== want.out_byte || o_out_data.status !== want.status
                    || o_out_data.last !== want.last) begin
                    errors++;
                    $display("%0t: result mismatch: expected byte %h status %0d last %0b, got byte %h status %0d last %0b",
                             $time, want.out_byte, want.status, want.last,
                             o_out_data.out_byte, o_out_data.status, o_out_data.last);
                end
            end
        end
    end

    // Watchdog
    initial begin : watchdog
        #400_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- json_string_unescape_utf8.f -----
+incdir+rtl
rtl/jsu_pkg.sv
rtl/jsu_front.sv
rtl/jsu_queue.sv
rtl/jsu_back.sv
rtl/json_string_unescape_utf8.sv
tb/sv/json_string_unescape_utf8_tb.sv
